/* src/cad_pkg.sv */
// ----------------------------------------------------------------------------
// cad_pkg
// shared types and codes for the 3d decay automaton
// ----------------------------------------------------------------------------
package cad_pkg;

  localparam int MASK_W     = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] LIFE_DEAD     = 2'd0;
  localparam logic [1:0] LIFE_ALIVE    = 2'd1;
  localparam logic [1:0] LIFE_DECAYING = 2'd2;
  localparam logic [1:0] LIFE_BAD      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DSTART = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] coord_x;
    logic [4:0] coord_y;
    logic [4:0] coord_z;
    logic [1:0] new_life;
    logic [7:0] new_decay;
  } cad_in_t;

  typedef struct packed {
    logic [1:0] done_kind;
    logic [1:0] cell_life;
    logic [7:0] cell_decay;
  } cad_out_t;

endpackage

/* src/cad_rule.sv */
// ----------------------------------------------------------------------------
// cad_rule
// next state of one cell from its state and alive neighbor count
// ----------------------------------------------------------------------------
module cad_rule #(
  parameter int DECAY_BITS = 8
) (
  input  logic [1:0]                  life_i,
  input  logic [DECAY_BITS-1:0]       decay_i,
  input  logic [4:0]                  count_i,
  input  logic [cad_pkg::MASK_W-1:0]  birth_mask_i,
  input  logic [cad_pkg::MASK_W-1:0]  stay_mask_i,
  input  logic [DECAY_BITS-1:0]       decay_start_i,
  output logic [1:0]                  life_o,
  output logic [DECAY_BITS-1:0]       decay_o
);

  logic [DECAY_BITS-1:0] dec_m1;

  always_comb begin
    dec_m1 = (decay_i != '0) ? decay_i - DECAY_BITS'(1) : '0;
    life_o = life_i;
    decay_o = decay_i;
    case (life_i)
      cad_pkg::LIFE_ALIVE: begin
        if (!stay_mask_i[count_i]) begin
          life_o = cad_pkg::LIFE_DECAYING;
          decay_o = decay_start_i;
        end
      end
      cad_pkg::LIFE_DECAYING: begin
        if (dec_m1 == '0) begin
          life_o = cad_pkg::LIFE_DEAD;
          decay_o = '0;
        end else begin
          decay_o = dec_m1;
        end
      end
      default: begin
        if (birth_mask_i[count_i]) begin
          life_o = cad_pkg::LIFE_ALIVE;
          decay_o = '0;
        end
      end
    endcase
  end

endmodule

/* src/cellular_automaton_3d_decay_step_top.sv */
// ----------------------------------------------------------------------------
// cellular_automaton_3d_decay_step_top
// cubic grid of dead, alive and decaying cells in two banks, with cell
// write, cell read and one-generation step
//
//   channel  ports                         handshake
//   input    start, busy, in_word          taken when start and not busy
//   result   out_valid, out_word           one-cycle strobe, never held off
//   config   cfg_we, cfg_index, cfg_wdata  written when cfg_we
//
// write and no-op answer in the cycle after acceptance, read answers from S_READ
// step streams (GRID_EDGE+1)^3 positions, then drains in S_DRAIN: the active bank is
// read once per position and plane and row buffers form the 3x3x3 window
// after reset a clearing pass zeroes every cell of bank 0, busy high
// the receiver cannot stall, so results leave as they are made
// ----------------------------------------------------------------------------
module cellular_automaton_3d_decay_step_top #(
  parameter int GRID_EDGE  = 32,
  parameter int DECAY_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  cad_pkg::cad_in_t                 in_word,
  output logic                             out_valid,
  output cad_pkg::cad_out_t                out_word,
  input  logic                             cfg_we,
  input  logic [cad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cad_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CELLS  = GRID_EDGE * GRID_EDGE * GRID_EDGE;
  localparam int AW     = $clog2(CELLS);
  localparam int EXT    = GRID_EDGE + 1;
  localparam int UW     = $clog2(EXT);
  localparam int PDEPTH = EXT * EXT;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int CW     = 2 + DECAY_BITS;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_STEP, S_DRAIN} state_t;

  state_t state_r;
  logic [AW-1:0] clr_r;
  logic sel_r;
  logic drain_r;
  logic [UW-1:0] ux_r, uy_r, uz_r;
  logic rd_in_r;
  logic out_valid_r;
  cad_pkg::cad_out_t out_word_r;

  logic [cad_pkg::MASK_W-1:0] birth_r, stay_r;
  logic [DECAY_BITS-1:0] dstart_r;

  logic [CW-1:0] bank0_mem [CELLS];
  logic [CW-1:0] bank1_mem [CELLS];
  logic [1:0] plane_mem [PDEPTH];
  logic [3:0] row_mem [EXT];

  logic [CW-1:0] ra0_r, ra1_r, rb0_r, rb1_r, ra_q, rb_q;
  logic [1:0] pq_r;
  logic [3:0] rq_r;

  logic acc, in_inside, s_inside, last_pos;
  logic [AW-1:0] in_addr, s_addr, ra_addr;
  logic [PAW-1:0] paddr0;
  logic [1:0] in_life;

  logic wr_en, wr_bank;
  logic [AW-1:0] wr_addr;
  logic [CW-1:0] wr_data;

  // stage 1
  logic v1_r, in1_r;
  logic [UW-1:0] u1x_r, u1y_r, u1z_r;
  logic [PAW-1:0] paddr1_r;
  logic a1;
  logic [1:0] s1;
  logic [3:0] r1;
  logic cv1;
  logic [AW-1:0] caddr1;

  // stage 2
  logic v2_r, cv2_r;
  logic [UW-1:0] u2x_r;
  logic [AW-1:0] caddr2_r;
  logic [3:0] r0_r, r1_r, r2_r;
  logic [4:0] total2, count2;
  logic c_alive;
  logic [1:0] new_life;
  logic [DECAY_BITS-1:0] new_decay;

  assign busy = (state_r != S_IDLE);
  assign acc = (state_r == S_IDLE) && start;
  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

  assign in_inside = (8'(in_word.coord_x) < 8'(GRID_EDGE)) &&
                     (8'(in_word.coord_y) < 8'(GRID_EDGE)) &&
                     (8'(in_word.coord_z) < 8'(GRID_EDGE));
  assign in_addr = AW'(in_word.coord_x) + AW'(in_word.coord_y) * AW'(GRID_EDGE) +
                   AW'(in_word.coord_z) * AW'(GRID_EDGE * GRID_EDGE);
  assign in_life = (in_word.new_life == cad_pkg::LIFE_BAD) ? cad_pkg::LIFE_DEAD
                                                           : in_word.new_life;

  assign s_inside = (ux_r < UW'(GRID_EDGE)) && (uy_r < UW'(GRID_EDGE)) &&
                    (uz_r < UW'(GRID_EDGE));
  assign s_addr = AW'(ux_r) + AW'(uy_r) * AW'(GRID_EDGE) +
                  AW'(uz_r) * AW'(GRID_EDGE * GRID_EDGE);
  assign paddr0 = PAW'(ux_r) + PAW'(uy_r) * PAW'(EXT);
  assign last_pos = (ux_r == UW'(GRID_EDGE)) && (uy_r == UW'(GRID_EDGE)) &&
                    (uz_r == UW'(GRID_EDGE));
  assign ra_addr = (state_r == S_STEP) ? s_addr : in_addr;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_r <= '0;
      stay_r <= '0;
      dstart_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cad_pkg::CFG_BIRTH:  birth_r <= cfg_wdata;
        cad_pkg::CFG_STAY:   stay_r <= cfg_wdata;
        cad_pkg::CFG_DSTART: dstart_r <= DECAY_BITS'(cfg_wdata[7:0]);
        default: ;
      endcase
    end
  end

  // single write port into the banks
  always_comb begin
    wr_en = 1'b0;
    wr_bank = 1'b0;
    wr_addr = clr_r;
    wr_data = '0;
    if (state_r == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (acc && in_word.operation == cad_pkg::OP_WRITE && in_inside) begin
      wr_en = 1'b1;
      wr_bank = sel_r;
      wr_addr = in_addr;
      wr_data = {in_life, DECAY_BITS'(in_word.new_decay)};
    end else if (v2_r && cv2_r) begin
      wr_en = 1'b1;
      wr_bank = ~sel_r;
      wr_addr = caddr2_r;
      wr_data = {new_life, new_decay};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank0_mem[wr_addr] <= wr_data;
    end
    ra0_r <= bank0_mem[ra_addr];
    rb0_r <= bank0_mem[caddr1];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) begin
      bank1_mem[wr_addr] <= wr_data;
    end
    ra1_r <= bank1_mem[ra_addr];
    rb1_r <= bank1_mem[caddr1];
  end

  assign ra_q = sel_r ? ra1_r : ra0_r;
  assign rb_q = sel_r ? rb1_r : rb0_r;

  // plane buffer: {alive at z-2, alive at z-1} per (x, y)
  always_ff @(posedge clk) begin
    if (v1_r) begin
      plane_mem[paddr1_r] <= {pq_r[0], a1};
    end
    pq_r <= plane_mem[paddr0];
  end

  // row buffer: {column sum at y-2, column sum at y-1} per x
  always_ff @(posedge clk) begin
    if (v1_r) begin
      row_mem[u1x_r] <= {rq_r[1:0], s1};
    end
    rq_r <= row_mem[ux_r];
  end

  // stage 1: column and row sums
  always_comb begin
    a1 = in1_r && (ra_q[CW-1 -: 2] == cad_pkg::LIFE_ALIVE);
    s1 = 2'(a1) + ((u1z_r != '0) ? 2'(pq_r[0]) : 2'd0) +
         ((u1z_r >= UW'(2)) ? 2'(pq_r[1]) : 2'd0);
    r1 = 4'(s1) + ((u1y_r != '0) ? 4'(rq_r[1:0]) : 4'd0) +
         ((u1y_r >= UW'(2)) ? 4'(rq_r[3:2]) : 4'd0);
    cv1 = (u1x_r != '0) && (u1y_r != '0) && (u1z_r != '0);
    caddr1 = AW'(u1x_r - UW'(1)) + AW'(u1y_r - UW'(1)) * AW'(GRID_EDGE) +
             AW'(u1z_r - UW'(1)) * AW'(GRID_EDGE * GRID_EDGE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_STEP);
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    in1_r <= s_inside;
    u1x_r <= ux_r;
    u1y_r <= uy_r;
    u1z_r <= uz_r;
    paddr1_r <= paddr0;
    if (v1_r) begin
      r0_r <= r1;
      r1_r <= r0_r;
      r2_r <= r1_r;
      u2x_r <= u1x_r;
      cv2_r <= cv1;
      caddr2_r <= caddr1;
    end
  end

  // stage 2: window total and rule
  always_comb begin
    c_alive = (rb_q[CW-1 -: 2] == cad_pkg::LIFE_ALIVE);
    total2 = 5'(r0_r) + ((u2x_r != '0) ? 5'(r1_r) : 5'd0) +
             ((u2x_r >= UW'(2)) ? 5'(r2_r) : 5'd0);
    count2 = total2 - 5'(c_alive);
  end

  cad_rule #(
    .DECAY_BITS(DECAY_BITS)
  ) u_rule (
    .life_i        (rb_q[CW-1 -: 2]),
    .decay_i       (rb_q[DECAY_BITS-1:0]),
    .count_i       (count2),
    .birth_mask_i  (birth_r),
    .stay_mask_i   (stay_r),
    .decay_start_i (dstart_r),
    .life_o        (new_life),
    .decay_o       (new_decay)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      sel_r <= 1'b0;
      drain_r <= 1'b0;
      ux_r <= '0;
      uy_r <= '0;
      uz_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CELLS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            out_word_r.done_kind <= in_word.operation;
            out_word_r.cell_life <= cad_pkg::LIFE_DEAD;
            out_word_r.cell_decay <= '0;
            rd_in_r <= in_inside;
            case (in_word.operation)
              cad_pkg::OP_READ: state_r <= S_READ;
              cad_pkg::OP_STEP: begin
                state_r <= S_STEP;
                ux_r <= '0;
                uy_r <= '0;
                uz_r <= '0;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          if (rd_in_r) begin
            out_word_r.cell_life <= ra_q[CW-1 -: 2];
            out_word_r.cell_decay <= 8'(ra_q[DECAY_BITS-1:0]);
          end
          state_r <= S_IDLE;
        end
        S_STEP: begin
          if (last_pos) begin
            state_r <= S_DRAIN;
            drain_r <= 1'b0;
          end else if (ux_r == UW'(GRID_EDGE)) begin
            ux_r <= '0;
            if (uy_r == UW'(GRID_EDGE)) begin
              uy_r <= '0;
              uz_r <= uz_r + UW'(1);
            end else begin
              uy_r <= uy_r + UW'(1);
            end
          end else begin
            ux_r <= ux_r + UW'(1);
          end
        end
        S_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) begin
            state_r <= S_IDLE;
            sel_r <= ~sel_r;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/cad_check.sv */
// ----------------------------------------------------------------------------
// cad_check
// port-level checks on the 3d decay automaton
// ----------------------------------------------------------------------------
module cad_check (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input cad_pkg::cad_in_t  in_word,
  input logic              out_valid,
  input cad_pkg::cad_out_t out_word
);

  // read holds busy for its bank read, then answers
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.operation == cad_pkg::OP_READ |=>
      busy ##1 (out_valid && out_word.done_kind == cad_pkg::OP_READ))
    else $error("read result not on time");

  // write and no-op answer in the next cycle
  a_write_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.operation == cad_pkg::OP_WRITE ||
                       in_word.operation == cad_pkg::OP_NONE) |=>
      out_valid && out_word.done_kind == $past(in_word.operation))
    else $error("write result not on time");

  // only reads carry cell data
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.done_kind != cad_pkg::OP_READ |->
      out_word.cell_life == cad_pkg::LIFE_DEAD && out_word.cell_decay == 8'd0)
    else $error("non-read word carries cell data");

  // a step holds the block busy
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.operation == cad_pkg::OP_STEP |=> busy && !out_valid)
    else $error("step did not hold busy");

endmodule

bind cellular_automaton_3d_decay_step_top cad_check u_cad_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 3d decay automaton: a queue-fed driver sends
// cell writes, reads, generation steps and no-ops in random bursts, a
// predictor keeps its own two-bank grid and the monitor compares each result
// word against the oldest predicted word
// ----------------------------------------------------------------------------
module tb_top;

  localparam int EDGE      = 32;
  localparam int CELLS     = EDGE * EDGE * EDGE;
  localparam int IDLE_LIMIT = 150000;

  typedef struct packed {
    logic [1:0] life;
    logic [7:0] decay;
  } cell_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  cad_pkg::cad_in_t               in_word = '0;
  logic                           out_valid;
  cad_pkg::cad_out_t              out_word;
  logic                           cfg_we = 1'b0;
  logic [cad_pkg::CFG_IDX_W-1:0]  cfg_index = cad_pkg::CFG_BIRTH;
  logic [cad_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  cad_pkg::cad_in_t  pending_q[$];
  cad_pkg::cad_out_t expect_q[$];
  cell_t    grid_bank[2][CELLS];
  bit       cur_bank;
  logic [26:0] birth_rule, stay_rule;
  logic [7:0]  decay_load;
  int err_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int steps_left;

  cellular_automaton_3d_decay_step_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int cell_at(int x, int y, int z);
    return x + y * EDGE + z * EDGE * EDGE;
  endfunction

  function automatic void run_generation();
    int n;
    int nx, ny, nz;
    cell_t c;
    for (int z = 0; z < EDGE; z++)
      for (int y = 0; y < EDGE; y++)
        for (int x = 0; x < EDGE; x++) begin
          n = 0;
          for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
              for (int dz = -1; dz <= 1; dz++) begin
                nx = x + dx;
                ny = y + dy;
                nz = z + dz;
                if ((dx != 0 || dy != 0 || dz != 0) && nx >= 0 && ny >= 0 && nz >= 0 &&
                    nx < EDGE && ny < EDGE && nz < EDGE &&
                    grid_bank[cur_bank][cell_at(nx, ny, nz)].life == cad_pkg::LIFE_ALIVE)
                  n++;
              end
          c = grid_bank[cur_bank][cell_at(x, y, z)];
          if (c.life == cad_pkg::LIFE_ALIVE) begin
            if (!stay_rule[n]) c = '{cad_pkg::LIFE_DECAYING, decay_load};
          end else if (c.life == cad_pkg::LIFE_DECAYING) begin
            if (c.decay > 8'd0) c.decay = c.decay - 8'd1;
            if (c.decay == 8'd0) c = '{cad_pkg::LIFE_DEAD, 8'd0};
          end else if (birth_rule[n]) begin
            c = '{cad_pkg::LIFE_ALIVE, 8'd0};
          end
          grid_bank[!cur_bank][cell_at(x, y, z)] = c;
        end
    cur_bank = !cur_bank;
  endfunction

  function automatic void predict_word(cad_pkg::cad_in_t w);
    cad_pkg::cad_out_t r;
    int idx;
    r = '0;
    r.done_kind = w.operation;
    idx = cell_at(int'(w.coord_x), int'(w.coord_y), int'(w.coord_z));
    case (w.operation)
      cad_pkg::OP_WRITE: grid_bank[cur_bank][idx] =
                  '{(w.new_life == cad_pkg::LIFE_BAD) ? cad_pkg::LIFE_DEAD : w.new_life,
                    w.new_decay};
      cad_pkg::OP_READ: begin
        r.cell_life  = grid_bank[cur_bank][idx].life;
        r.cell_decay = grid_bank[cur_bank][idx].decay;
      end
      cad_pkg::OP_STEP: run_generation();
      default: ;
    endcase
    expect_q = {expect_q, r};
  endfunction

  function automatic cad_pkg::cad_in_t mk(logic [1:0] op, int x, int y, int z,
                                          logic [1:0] life, logic [7:0] decay);
    cad_pkg::cad_in_t w;
    w.operation = op;
    w.coord_x = 5'(x);
    w.coord_y = 5'(y);
    w.coord_z = 5'(z);
    w.new_life = life;
    w.new_decay = decay;
    return w;
  endfunction

  function automatic int near(int b);
    int v;
    v = b + int'($urandom_range(0, 2)) - 1;
    return (v < 0) ? 0 : (v > EDGE - 1) ? EDGE - 1 : v;
  endfunction

  task automatic queue_word(cad_pkg::cad_in_t w);
    pending_q = {pending_q, w};
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) predict_word(in_word);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_word <= pending_q.pop_front();
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cad_pkg::cad_out_t e;
    if (rst_n && out_valid) begin
      if (expect_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        e = expect_q.pop_front();
        if (out_word.done_kind !== e.done_kind)
          report_mismatch($sformatf("done_kind %0d, expected %0d",
                                    out_word.done_kind, e.done_kind));
        if (out_word.cell_life !== e.cell_life)
          report_mismatch($sformatf("cell_life %0d, expected %0d",
                                    out_word.cell_life, e.cell_life));
        if (out_word.cell_decay !== e.cell_decay)
          report_mismatch($sformatf("cell_decay %0d, expected %0d",
                                    out_word.cell_decay, e.cell_decay));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || start || expect_q.size() != 0 || busy);
    repeat (5) @(posedge clk);
  endtask

  task automatic cfg_write(logic [cad_pkg::CFG_IDX_W-1:0] idx,
                           logic [cad_pkg::CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      cad_pkg::CFG_BIRTH:  birth_rule = v;
      cad_pkg::CFG_STAY:   stay_rule = v;
      cad_pkg::CFG_DSTART: decay_load = v[7:0];
      default: ;
    endcase
  endtask

  task automatic set_rules(logic [26:0] b, logic [26:0] s, logic [7:0] d);
    cfg_write(cad_pkg::CFG_BIRTH, b);
    cfg_write(cad_pkg::CFG_STAY, s);
    cfg_write(cad_pkg::CFG_DSTART, {19'd0, d});
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int added;
    int bx, by, bz;
    logic [1:0] life;
    added = 0;
    steps_left = 2;
    while (added < count) begin
      if ($urandom_range(0, 9) < 6) begin
        bx = $urandom_range(0, EDGE - 1);
        by = $urandom_range(0, EDGE - 1);
        bz = $urandom_range(0, EDGE - 1);
        repeat ($urandom_range(3, 6)) begin
          life = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                             : cad_pkg::LIFE_ALIVE;
          queue_word(mk(cad_pkg::OP_WRITE, near(bx), near(by), near(bz), life,
                        8'($urandom_range(0, 255))));
          added++;
        end
        if (steps_left > 0 && $urandom_range(0, 2) == 0) begin
          queue_word(mk(cad_pkg::OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 31), 2'($urandom_range(0, 3)),
                        8'($urandom_range(0, 255))));
          steps_left--;
          added++;
        end
        repeat ($urandom_range(2, 4)) begin
          queue_word(mk(cad_pkg::OP_READ, near(bx), near(by), near(bz),
                        2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
          added++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0: life = cad_pkg::OP_WRITE;
          1: life = cad_pkg::OP_READ;
          default: life = cad_pkg::OP_NONE;
        endcase
        queue_word(mk(life, $urandom_range(0, 31), $urandom_range(0, 31),
                      $urandom_range(0, 31), 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255))));
        added++;
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < CELLS; i++) grid_bank[b][i] = '0;
    cur_bank = 1'b0;
    birth_rule = '0;
    stay_rule = '0;
    decay_load = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // reset rules: alive cells decay from zero and die one step later
    queue_word(mk(cad_pkg::OP_READ, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 31, 31, 31, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_WRITE, 0, 0, 0, cad_pkg::LIFE_ALIVE, 8'd255));
    queue_word(mk(cad_pkg::OP_WRITE, 31, 31, 31, cad_pkg::LIFE_BAD, 8'hAA));
    queue_word(mk(cad_pkg::OP_WRITE, 31, 0, 31, cad_pkg::LIFE_DECAYING, 8'd1));
    queue_word(mk(cad_pkg::OP_WRITE, 0, 31, 0, cad_pkg::LIFE_DECAYING, 8'd0));
    queue_word(mk(cad_pkg::OP_WRITE, 1, 1, 1, cad_pkg::LIFE_DECAYING, 8'd200));
    queue_word(mk(cad_pkg::OP_READ, 0, 0, 0, cad_pkg::LIFE_BAD, 8'hFF));
    queue_word(mk(cad_pkg::OP_READ, 31, 31, 31, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_NONE, 31, 31, 31, cad_pkg::LIFE_BAD, 8'hFF));
    queue_word(mk(cad_pkg::OP_STEP, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 31, 0, 31, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 0, 31, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 1, 1, 1, cad_pkg::LIFE_DEAD, 8'd0));
    wait_idle();

    // everything born, then everything stays
    set_rules(27'h7FFFFFF, 27'h7FFFFFF, 8'hFF);
    queue_word(mk(cad_pkg::OP_STEP, 5, 5, 5, cad_pkg::LIFE_ALIVE, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 17, 9, 30, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_STEP, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    wait_idle();

    // nothing stays, zero decay start
    set_rules(27'd0, 27'd0, 8'd0);
    queue_word(mk(cad_pkg::OP_STEP, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 12, 3, 7, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_STEP, 0, 0, 0, cad_pkg::LIFE_DEAD, 8'd0));
    queue_word(mk(cad_pkg::OP_READ, 31, 31, 31, cad_pkg::LIFE_DEAD, 8'd0));
    wait_idle();

    set_rules(27'h0000030, 27'h0000070, 8'd1);
    random_phase(18);
    repeat (3) begin
      set_rules(27'($urandom) & 27'h7FFFFFE, 27'($urandom), 8'($urandom_range(0, 255)));
      random_phase(18);
    end

    repeat (50) @(posedge clk);
    if (err_count == 0 && expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
